[hw/rtl/fcpa_pkg.sv]
// Package for the fixed chunk pool allocator.
// Holds command and status codes, controller states and the control bundle.
// Used by fcpa_ctrl, fcpa_dp and fixed_chunk_pool_allocator.
package fcpa_pkg;

  localparam int IDX_W  = 8;
  localparam int CNT_W  = 9;
  localparam int SIZE_W = 16;
  localparam int OFF_W  = 24;
  localparam int CHK_W  = 17;

  localparam int MAX_CHUNKS = 256;

  localparam logic [SIZE_W-1:0] LARGEST_RST = 16'd64;
  localparam logic [CNT_W-1:0]  COUNT_RST   = 9'd256;
  localparam logic [CNT_W-1:0]  COUNT_MIN   = 9'd1;
  localparam logic [CNT_W-1:0]  COUNT_MAX   = 9'd256;

  // Configuration register indexes.
  localparam logic CFG_LARGEST = 1'b0;
  localparam logic CFG_COUNT   = 1'b1;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RESIZE  = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_QUERY   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_ALLOC = 2'd2
  } stat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_SCALE
  } fsm_t;

  typedef struct packed {
    logic capture;
    logic commit;
    logic finish;
  } ctl_t;

endpackage

[hw/rtl/fcpa_ctrl.sv]
// Controller of the fixed chunk pool allocator.
// Sequences capture, commit and finish of one command; uses fcpa_pkg.
module fcpa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output fcpa_pkg::ctl_t ctl
);

  fcpa_pkg::fsm_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fcpa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    busy        = 1'b1;
    ctl.capture = 1'b0;
    ctl.commit  = 1'b0;
    ctl.finish  = 1'b0;
    unique case (state)
      fcpa_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.capture = 1'b1;
          state_next  = fcpa_pkg::S_LOOKUP;
        end
      end
      fcpa_pkg::S_LOOKUP: begin
        ctl.commit = 1'b1;
        state_next = fcpa_pkg::S_SCALE;
      end
      fcpa_pkg::S_SCALE: begin
        ctl.finish = 1'b1;
        state_next = fcpa_pkg::S_IDLE;
      end
      default: begin
        state_next = fcpa_pkg::S_IDLE;
      end
    endcase
  end

  // Only one of the three steps may be commanded in a cycle.
  a_ctl_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.capture, ctl.commit, ctl.finish}))
    else $error("controller issued more than one step at once");

  a_capture_then_commit: assert property (@(posedge clk) disable iff (rst)
    ctl.capture |=> ctl.commit ##1 ctl.finish)
    else $error("command sequence broken after capture");

  a_busy_not_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.commit |-> busy)
    else $error("busy low while a command is being committed");

endmodule

[hw/rtl/fcpa_dp.sv]
// Datapath of the fixed chunk pool allocator: config registers, free stack,
// recorded sizes, counters, chunk size unit and result registers; uses fcpa_pkg.
module fcpa_dp #(
  parameter int ALIGN_BYTES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  fcpa_pkg::ctl_t                ctl,
  input  logic [1:0]                    command,
  input  logic [fcpa_pkg::IDX_W-1:0]    chunk_index,
  input  logic [fcpa_pkg::SIZE_W-1:0]   request_size,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [15:0]                   cfg_data,
  output logic                          done,
  output logic [1:0]                    status,
  output logic [fcpa_pkg::IDX_W-1:0]    granted_index,
  output logic [fcpa_pkg::OFF_W-1:0]    byte_offset,
  output logic [fcpa_pkg::CNT_W-1:0]    free_count,
  output logic [fcpa_pkg::CNT_W-1:0]    in_use_count,
  output logic [fcpa_pkg::CNT_W-1:0]    high_water
);

  localparam int IW = fcpa_pkg::IDX_W;
  localparam int CW = fcpa_pkg::CNT_W;
  localparam int SW = fcpa_pkg::SIZE_W;
  localparam int KW = fcpa_pkg::CHK_W;
  localparam int DEPTH = fcpa_pkg::MAX_CHUNKS;

  // Chunk size = ceil(largest / ALIGN) * ALIGN, with the quotient taken by a
  // reciprocal multiply that is exact for every 17-bit dividend.
  localparam int ALIGN_W  = $clog2(ALIGN_BYTES + 1);
  localparam int RECIP_SH = 24;
  localparam int RECIP_W  = RECIP_SH + 1;
  localparam longint RECIP = ((64'd1 << RECIP_SH) + ALIGN_BYTES - 1) / ALIGN_BYTES;
  localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);
  localparam logic [ALIGN_W-1:0] ALIGN_V = ALIGN_W'(ALIGN_BYTES);
  localparam logic [KW-1:0] ROUND_ADD = KW'(ALIGN_BYTES - 1);
  localparam int Q_RST = (64 + ALIGN_BYTES - 1) / ALIGN_BYTES;
  localparam logic [KW-1:0] QUOT_RST  = KW'(Q_RST);
  localparam logic [KW-1:0] CHUNK_RST = KW'(Q_RST * ALIGN_BYTES);

  logic [SW-1:0] largest_size;
  logic [CW-1:0] chunk_count;
  logic [CW-1:0] free_depth;
  logic [CW-1:0] peak_in_use;

  logic [KW-1:0]              quot;
  logic [KW-1:0]              chunk_bytes;
  logic [KW-1:0]              rounded;
  logic [KW+RECIP_W-1:0]      recip_prod;
  logic [KW+ALIGN_W-1:0]      chunk_prod;

  logic [IW-1:0] stack_mem [DEPTH];
  logic [SW-1:0] size_mem  [DEPTH];
  logic          size_valid [DEPTH];

  fcpa_pkg::cmd_t cmd_q;
  logic [IW-1:0]  idx_q;
  logic [SW-1:0]  size_q;
  logic [IW-1:0]  stack_rd;
  logic [SW-1:0]  size_rd;
  logic           size_vld_q;

  logic [CW-1:0]  sp_top;
  logic [CW:0]    depth_peak_sum;
  logic           pop_implicit;
  logic [CW-1:0]  implicit_val;
  logic [CW-1:0]  alloc_in_use;
  logic           idx_ok;
  logic           rec_nz;
  logic [CW-1:0]  count_clamped;

  fcpa_pkg::stat_t status_n;
  logic [IW-1:0]   granted_n;
  logic            ok_n;
  logic [CW-1:0]   depth_n;
  logic [CW-1:0]   peak_n;
  logic            size_we;
  logic [IW-1:0]   size_wa;
  logic            vld_we;
  logic            vld_wd;
  logic            stack_we;

  fcpa_pkg::stat_t stat_q;
  logic [IW-1:0]   granted_q;
  logic            ok_q;
  logic [IW+KW-1:0] offset_full;

  // Chunk size unit: two registered stages behind largest_size.
  assign rounded    = {1'b0, largest_size} + ROUND_ADD;
  assign recip_prod = rounded * RECIP_V;
  assign chunk_prod = quot * ALIGN_V;

  always_ff @(posedge clk) begin
    if (rst) begin
      quot        <= QUOT_RST;
      chunk_bytes <= CHUNK_RST;
    end else begin
      quot        <= recip_prod[RECIP_SH +: KW];
      chunk_bytes <= chunk_prod[KW-1:0];
    end
  end

  always_comb begin
    count_clamped = cfg_data[CW-1:0];
    if (cfg_data[CW-1:0] == '0) begin
      count_clamped = fcpa_pkg::COUNT_MIN;
    end else if (cfg_data[CW-1:0] > fcpa_pkg::COUNT_MAX) begin
      count_clamped = fcpa_pkg::COUNT_MAX;
    end
  end

  // Stack slots below chunk_count - peak_in_use have not been written since
  // the last rebuild; a pop from them takes the index chunk_count - free_depth.
  assign sp_top         = free_depth - 1'b1;
  assign depth_peak_sum = {1'b0, free_depth} + {1'b0, peak_in_use};
  assign pop_implicit   = depth_peak_sum <= {1'b0, chunk_count};
  assign implicit_val   = chunk_count - free_depth;
  assign alloc_in_use   = chunk_count - sp_top;
  assign idx_ok         = {1'b0, idx_q} < chunk_count;
  assign rec_nz         = size_vld_q && (size_rd != '0);

  always_comb begin
    status_n  = fcpa_pkg::ST_OK;
    granted_n = '0;
    ok_n      = 1'b0;
    depth_n   = free_depth;
    peak_n    = peak_in_use;
    size_we   = 1'b0;
    size_wa   = idx_q;
    vld_we    = 1'b0;
    vld_wd    = 1'b1;
    stack_we  = 1'b0;
    unique case (cmd_q)
      fcpa_pkg::CMD_ALLOC: begin
        if (free_depth == '0 || free_depth > chunk_count) begin
          status_n = fcpa_pkg::ST_EMPTY;
        end else begin
          granted_n = pop_implicit ? implicit_val[IW-1:0] : stack_rd;
          depth_n   = sp_top;
          size_we   = 1'b1;
          size_wa   = granted_n;
          vld_we    = 1'b1;
          ok_n      = 1'b1;
          if (alloc_in_use > peak_in_use) begin
            peak_n = alloc_in_use;
          end
        end
      end
      fcpa_pkg::CMD_RESIZE: begin
        granted_n = idx_q;
        if (idx_ok && rec_nz) begin
          size_we = 1'b1;
          vld_we  = 1'b1;
          ok_n    = 1'b1;
        end else begin
          status_n = fcpa_pkg::ST_NOT_ALLOC;
        end
      end
      fcpa_pkg::CMD_RELEASE: begin
        granted_n = idx_q;
        if (idx_ok && rec_nz && free_depth < chunk_count) begin
          vld_we   = 1'b1;
          vld_wd   = 1'b0;
          stack_we = 1'b1;
          depth_n  = free_depth + 1'b1;
          ok_n     = 1'b1;
        end else begin
          status_n = fcpa_pkg::ST_NOT_ALLOC;
        end
      end
      fcpa_pkg::CMD_QUERY: begin
      end
      default: begin
      end
    endcase
  end

  // Config registers and pool counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      largest_size <= fcpa_pkg::LARGEST_RST;
      chunk_count  <= fcpa_pkg::COUNT_RST;
      free_depth   <= fcpa_pkg::COUNT_RST;
      peak_in_use  <= '0;
    end else if (cfg_we) begin
      if (cfg_index == fcpa_pkg::CFG_LARGEST) begin
        largest_size <= cfg_data;
      end else begin
        chunk_count <= count_clamped;
        free_depth  <= count_clamped;
        peak_in_use <= '0;
      end
    end else if (ctl.commit) begin
      free_depth  <= depth_n;
      peak_in_use <= peak_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (cfg_we && cfg_index == fcpa_pkg::CFG_COUNT)) begin
      for (int i = 0; i < DEPTH; i++) begin
        size_valid[i] <= 1'b0;
      end
    end else if (ctl.commit && vld_we) begin
      size_valid[size_wa] <= vld_wd;
    end
  end

  // Stack and size memories: read at capture, written at commit.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      stack_rd <= stack_mem[sp_top[IW-1:0]];
    end
    if (ctl.commit && stack_we) begin
      stack_mem[free_depth[IW-1:0]] <= idx_q;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      size_rd <= size_mem[chunk_index];
    end
    if (ctl.commit && size_we) begin
      size_mem[size_wa] <= size_q;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q      <= fcpa_pkg::cmd_t'(command);
      idx_q      <= chunk_index;
      size_q     <= request_size;
      size_vld_q <= size_valid[chunk_index];
    end
    if (ctl.commit) begin
      stat_q    <= status_n;
      granted_q <= granted_n;
      ok_q      <= ok_n;
    end
  end

  assign offset_full = granted_q * chunk_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      status        <= stat_q;
      granted_index <= granted_q;
      byte_offset   <= ok_q ? offset_full[fcpa_pkg::OFF_W-1:0] : '0;
      free_count    <= free_depth;
      in_use_count  <= chunk_count - free_depth;
      high_water    <= peak_in_use;
    end
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    free_depth <= chunk_count)
    else $error("free stack deeper than the pool");

  a_peak_bound: assert property (@(posedge clk) disable iff (rst)
    depth_peak_sum >= {1'b0, chunk_count})
    else $error("high-water mark below chunks in use");

  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    ctl.capture |-> ##3 done)
    else $error("result beat missing three cycles after capture");

  a_empty_means_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == fcpa_pkg::ST_EMPTY) |-> (free_count == '0 && byte_offset == '0))
    else $error("pool empty reported with chunks on the free stack");

endmodule

[hw/rtl/fixed_chunk_pool_allocator.sv]
// Each command (allocate, resize, release, query) is accepted when start is
// high and busy is low; its result beat appears on the result ports for one
// cycle, marked by done, after the capture, commit and finish states, and busy
// is already low in that cycle, so the next command can be accepted then.
// The path runs through the registered reads of the free stack and size
// memories, the commit cycle that writes them back, and the registered
// index-times-chunk-size multiply. The receiver cannot stall the result beat.
// A new largest_size reaches the chunk size through the quot and chunk_bytes
// registers; a chunk_count write rebuilds the pool at once, with no clearing
// pass. Top level; instantiates fcpa_ctrl and fcpa_dp and uses fcpa_pkg.
module fixed_chunk_pool_allocator #(
  parameter int ALIGN_BYTES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    command,
  input  logic [fcpa_pkg::IDX_W-1:0]    chunk_index,
  input  logic [fcpa_pkg::SIZE_W-1:0]   request_size,
  output logic                          done,
  output logic [1:0]                    status,
  output logic [fcpa_pkg::IDX_W-1:0]    granted_index,
  output logic [fcpa_pkg::OFF_W-1:0]    byte_offset,
  output logic [fcpa_pkg::CNT_W-1:0]    free_count,
  output logic [fcpa_pkg::CNT_W-1:0]    in_use_count,
  output logic [fcpa_pkg::CNT_W-1:0]    high_water,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [15:0]                   cfg_data
);

  fcpa_pkg::ctl_t ctl;
  logic           cfg_we;

  assign cfg_ready = !busy;
  assign cfg_we    = cfg_valid && cfg_ready;

  fcpa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .ctl   (ctl)
  );

  fcpa_dp #(
    .ALIGN_BYTES (ALIGN_BYTES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .command       (command),
    .chunk_index   (chunk_index),
    .request_size  (request_size),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .done          (done),
    .status        (status),
    .granted_index (granted_index),
    .byte_offset   (byte_offset),
    .free_count    (free_count),
    .in_use_count  (in_use_count),
    .high_water    (high_water)
  );

endmodule
